FILE: hw/rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg: shared types and constants of the furnace relay controller
// Holds the item kinds, the register map, the configuration record and the
// controller flag record that travel between the modules of the block.
// ----------------------------------------------------------------------------
package frc_pkg;

    // Fixed widths of the configuration registers.
    localparam int LIM_W  = 12;
    localparam int HOLD_W = 26;

    // APB register map: register index is paddr[4:2].
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 32;

    localparam logic [IDX_W-1:0] REG_HIGH_HIGH = 3'd0;
    localparam logic [IDX_W-1:0] REG_HIGH      = 3'd1;
    localparam logic [IDX_W-1:0] REG_LOW       = 3'd2;
    localparam logic [IDX_W-1:0] REG_LOW_LOW   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DOOR_HOLD = 3'd4;
    localparam logic [IDX_W-1:0] REG_HEAT_TMO  = 3'd5;

    // Reset values of the registers.
    localparam logic [LIM_W-1:0]  RST_HIGH_HIGH = 12'd1400;
    localparam logic [LIM_W-1:0]  RST_HIGH      = 12'd1200;
    localparam logic [LIM_W-1:0]  RST_LOW       = 12'd400;
    localparam logic [LIM_W-1:0]  RST_LOW_LOW   = 12'd200;
    localparam logic [HOLD_W-1:0] RST_DOOR_HOLD = 26'd3000;
    localparam logic [HOLD_W-1:0] RST_HEAT_TMO  = 26'd1800000;

    // Item kinds carried in the input tuser.
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_DOOR = 2'd1,
        OP_TEMP = 2'd2
    } t_op;

    typedef struct packed {
        logic [LIM_W-1:0]  high_high_limit;
        logic [LIM_W-1:0]  high_limit;
        logic [LIM_W-1:0]  low_limit;
        logic [LIM_W-1:0]  low_low_limit;
        logic [HOLD_W-1:0] door_hold_ms;
        logic [HOLD_W-1:0] heat_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic trip;
        logic startup;
        logic by_switch;
        logic heat;
        logic ember;
        logic request;
        logic tracking;
    } t_flags;

endpackage

FILE: hw/rtl/frc_cfg_regs.sv
// ----------------------------------------------------------------------------
// frc_cfg_regs: APB configuration registers
// Holds the four temperature limits and the two time limits, with reads.
// ----------------------------------------------------------------------------
module frc_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [frc_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [frc_pkg::DATA_W-1:0]   i_pwdata,
    output logic [frc_pkg::DATA_W-1:0]   o_prdata,
    output frc_pkg::t_cfg                o_cfg
);
    import frc_pkg::*;

    t_cfg             r_cfg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign idx   = i_paddr[ADDR_W-1:2];
    assign wr_en = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_high_limit <= RST_HIGH_HIGH;
            r_cfg.high_limit      <= RST_HIGH;
            r_cfg.low_limit       <= RST_LOW;
            r_cfg.low_low_limit   <= RST_LOW_LOW;
            r_cfg.door_hold_ms    <= RST_DOOR_HOLD;
            r_cfg.heat_timeout_ms <= RST_HEAT_TMO;
        end else if (wr_en) begin
            case (idx)
                REG_HIGH_HIGH: r_cfg.high_high_limit <= i_pwdata[LIM_W-1:0];
                REG_HIGH:      r_cfg.high_limit      <= i_pwdata[LIM_W-1:0];
                REG_LOW:       r_cfg.low_limit       <= i_pwdata[LIM_W-1:0];
                REG_LOW_LOW:   r_cfg.low_low_limit   <= i_pwdata[LIM_W-1:0];
                REG_DOOR_HOLD: r_cfg.door_hold_ms    <= i_pwdata[HOLD_W-1:0];
                REG_HEAT_TMO:  r_cfg.heat_timeout_ms <= i_pwdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_HIGH_HIGH: o_prdata = DATA_W'(r_cfg.high_high_limit);
            REG_HIGH:      o_prdata = DATA_W'(r_cfg.high_limit);
            REG_LOW:       o_prdata = DATA_W'(r_cfg.low_limit);
            REG_LOW_LOW:   o_prdata = DATA_W'(r_cfg.low_low_limit);
            REG_DOOR_HOLD: o_prdata = DATA_W'(r_cfg.door_hold_ms);
            REG_HEAT_TMO:  o_prdata = DATA_W'(r_cfg.heat_timeout_ms);
            default:       o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/frc_step.sv
// ----------------------------------------------------------------------------
// frc_step: next-state logic for one item
// Advances the timers, qualifies door presses and runs the temperature
// priority chain, giving the controller state after the item.
// ----------------------------------------------------------------------------
module frc_step #(
    parameter int TIMER_BITS = 26,
    parameter int TEMP_BITS  = 13
) (
    input  frc_pkg::t_op                   i_op,
    input  logic                           i_door,
    input  logic signed [TEMP_BITS-1:0]    i_temp,
    input  frc_pkg::t_cfg                  i_cfg,
    input  frc_pkg::t_flags                i_flags,
    input  logic [TIMER_BITS-1:0]          i_press_timer,
    input  logic [TIMER_BITS-1:0]          i_heat_timer,
    output frc_pkg::t_flags                o_flags,
    output logic [TIMER_BITS-1:0]          o_press_timer,
    output logic [TIMER_BITS-1:0]          o_heat_timer,
    output logic                           o_report_valid
);
    import frc_pkg::*;

    // Comparison widths wide enough for both operands.
    localparam int TW    = (TIMER_BITS > HOLD_W) ? TIMER_BITS : HOLD_W;
    localparam int CMP_W = ((TEMP_BITS - 1) > LIM_W) ? (TEMP_BITS - 1) : LIM_W;

    logic [CMP_W-1:0] t;
    logic             temp_ok;
    logic             ge_hh, le_h, ge_h, lt_ll, ge_l, lt_h;
    logic             press_done, heat_expired;

    assign t       = CMP_W'(i_temp[TEMP_BITS-2:0]);
    assign temp_ok = !i_temp[TEMP_BITS-1];

    assign ge_hh = t >= CMP_W'(i_cfg.high_high_limit);
    assign le_h  = t <= CMP_W'(i_cfg.high_limit);
    assign ge_h  = t >= CMP_W'(i_cfg.high_limit);
    assign lt_h  = !ge_h;
    assign lt_ll = t <  CMP_W'(i_cfg.low_low_limit);
    assign ge_l  = t >= CMP_W'(i_cfg.low_limit);

    assign press_done   = TW'(i_press_timer) >= TW'(i_cfg.door_hold_ms);
    assign heat_expired = TW'(i_heat_timer) >= TW'(i_cfg.heat_timeout_ms);

    always_comb begin
        t_flags f;
        f              = i_flags;
        o_press_timer  = i_press_timer;
        o_heat_timer   = i_heat_timer;
        o_report_valid = 1'b0;
        case (i_op)
            OP_TICK: begin
                // Both timers saturate at all ones.
                if (i_flags.tracking && !(&i_press_timer)) begin
                    o_press_timer = i_press_timer + TIMER_BITS'(1);
                end
                if (!(&i_heat_timer)) begin
                    o_heat_timer = i_heat_timer + TIMER_BITS'(1);
                end
            end
            OP_DOOR: begin
                // Door samples are ignored while startup heating runs.
                if (!i_flags.startup) begin
                    if (!i_door) begin
                        f.tracking = 1'b0;
                    end else if (!i_flags.tracking) begin
                        f.tracking    = 1'b1;
                        o_press_timer = '0;
                    end else if (press_done) begin
                        f.request  = 1'b1;
                        f.tracking = 1'b0;
                    end
                end
            end
            OP_TEMP: begin
                if (temp_ok) begin
                    o_report_valid = 1'b1;
                    if (ge_hh) begin
                        f.trip      = 1'b1;
                        f.startup   = 1'b0;
                        f.by_switch = 1'b0;
                        f.ember     = 1'b0;
                        f.request   = 1'b0;
                    end else if (i_flags.trip && le_h) begin
                        f.trip = 1'b0;
                    end else if (i_flags.request && !i_flags.startup) begin
                        f.heat      = 1'b1;
                        f.startup   = 1'b1;
                        f.by_switch = 1'b1;
                        f.ember     = 1'b0;
                        f.request   = 1'b0;
                    end else if (i_flags.startup && ge_h) begin
                        f.heat      = 1'b0;
                        f.startup   = 1'b0;
                        f.by_switch = 1'b0;
                        f.request   = 1'b0;
                    end else if (lt_ll && !i_flags.heat && !i_flags.startup &&
                                 !i_flags.ember) begin
                        f.heat       = 1'b1;
                        o_heat_timer = '0;
                    end else if (i_flags.heat && !i_flags.by_switch && heat_expired &&
                                 lt_ll) begin
                        f.heat  = 1'b0;
                        f.ember = 1'b1;
                    end else if (i_flags.heat && !i_flags.startup && ge_l && lt_h) begin
                        f.heat  = 1'b0;
                        f.ember = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        o_flags = f;
    end

endmodule

FILE: hw/rtl/furnace_relay_controller_core.sv
// ----------------------------------------------------------------------------
// furnace_relay_controller_core: furnace trip and forced-heat relay control
// Streams ticks, door samples and temperature samples in, one relay status
// transaction out per input transaction, with an APB register port.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock cycle when the output side
// does not hold it back, and returns exactly one output transaction for each,
// in order. An input transaction is held in an input register; when it
// advances, the next-state logic updates the controller flags and timers and
// loads the result register. The only thing that slows the input side is
// backpressure from the output side: a result waiting in the result register
// does not stop the input register from filling, and the input stage advances
// whenever the result register is empty or being drained. The input tuser
// carries the item kind (tick, door sample, temperature sample); the output
// tuser is set for a temperature sample with a valid (non-negative) reading.
// The user must write the registers only while no transaction is in flight;
// the block itself does not enforce this.
module furnace_relay_controller_core #(
    parameter int TIMER_BITS = 26,
    parameter int TEMP_BITS  = 13
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata, from bit 0: door_level (1), temp_quarters (TEMP_BITS), zero fill.
    input  logic [((TEMP_BITS+8)/8)*8-1:0]  i_s_axis_tdata,
    // tuser: op (2).
    input  logic [1:0]                      i_s_axis_tuser,
    // Output stream.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata, from bit 0: trip_relay, heat_relay, startup_on, ember_on,
    // start_pending, three zero bits.
    output logic [7:0]                      o_m_axis_tdata,
    // tuser: report_valid (1).
    output logic                            o_m_axis_tuser,
    // APB register port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [frc_pkg::ADDR_W-1:0]      paddr,
    input  logic [frc_pkg::DATA_W-1:0]      pwdata,
    output logic [frc_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import frc_pkg::*;

    t_cfg cfg;

    // Input register.
    logic                        r_in_valid;
    t_op                         r_in_op;
    logic                        r_in_door;
    logic signed [TEMP_BITS-1:0] r_in_temp;

    // Controller state.
    t_flags                r_flags, n_flags;
    logic [TIMER_BITS-1:0] r_press_timer, n_press_timer;
    logic [TIMER_BITS-1:0] r_heat_timer, n_heat_timer;
    logic                  n_report_valid;

    // Result register.
    logic       r_out_valid;
    logic [4:0] r_out_status;
    logic       r_out_report;

    logic s_accept;
    logic advance;

    // The input stage moves on whenever the result register can take a result.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign pready = 1'b1;

    frc_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    frc_step #(
        .TIMER_BITS (TIMER_BITS),
        .TEMP_BITS  (TEMP_BITS)
    ) u_step (
        .i_op           (r_in_op),
        .i_door         (r_in_door),
        .i_temp         (r_in_temp),
        .i_cfg          (cfg),
        .i_flags        (r_flags),
        .i_press_timer  (r_press_timer),
        .i_heat_timer   (r_heat_timer),
        .o_flags        (n_flags),
        .o_press_timer  (n_press_timer),
        .o_heat_timer   (n_heat_timer),
        .o_report_valid (n_report_valid)
    );

    // Input register: payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_op   <= t_op'(i_s_axis_tuser);
            r_in_door <= i_s_axis_tdata[0];
            r_in_temp <= i_s_axis_tdata[TEMP_BITS:1];
        end
    end

    // State update and result register load happen together, so each item
    // sees the state left by the item before it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags       <= '0;
            r_press_timer <= '0;
            r_heat_timer  <= '0;
        end else if (advance) begin
            r_flags       <= n_flags;
            r_press_timer <= n_press_timer;
            r_heat_timer  <= n_heat_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_status <= {n_flags.request, n_flags.ember, n_flags.startup,
                             n_flags.heat, n_flags.trip};
            r_out_report <= n_report_valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_status};
    assign o_m_axis_tuser  = r_out_report;

endmodule

FILE: hw/rtl/frc_checker.sv
// ----------------------------------------------------------------------------
// frc_checker: port-level checks of the furnace relay controller
// Checks relay status consistency and output stall behavior over time.
// ----------------------------------------------------------------------------
module frc_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    input  logic [7:0] o_m_axis_tdata,
    input  logic       o_m_axis_tuser
);
    logic trip, heat, startup, ember, pending;

    assign trip    = o_m_axis_tdata[0];
    assign heat    = o_m_axis_tdata[1];
    assign startup = o_m_axis_tdata[2];
    assign ember   = o_m_axis_tdata[3];
    assign pending = o_m_axis_tdata[4];

    // Startup heating always drives the forced-heat relay.
    a_startup_heat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && startup |-> heat)
        else $error("startup active without heat relay");

    // Ember hold and forced heat exclude each other.
    a_ember_heat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && ember |-> !heat && !startup)
        else $error("ember hold together with heat or startup");

    // A pending start request is consumed when startup begins.
    a_pending_startup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && pending |-> !startup)
        else $error("start request pending during startup");

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output transaction changed while stalled");

endmodule

bind furnace_relay_controller_core frc_checker u_frc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

FILE: sim/furnace_relay_controller_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// furnace_relay_controller_core_tb: self-checking bench for the relay core
// Streams ticks, door samples and temperature samples into the core, predicts
// the relay status of every transaction and compares it field by field.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic trip_relay;
    logic heat_relay;
    logic startup_on;
    logic ember_on;
    logic start_pending;
    logic report_valid;
} t_relay_status;

class relay_scoreboard;
    logic [frc_pkg::LIM_W-1:0]  trip_level, upper_level, heat_stop_level, heat_start_level;
    logic [frc_pkg::HOLD_W-1:0] door_hold, heat_timeout;
    logic                       trip, startup, by_switch, heat, ember, request, tracking;
    logic [frc_pkg::HOLD_W-1:0] press_ms, heat_ms;
    t_relay_status              expected_status[$];
    int                         errors;

    function new();
        trip_level       = frc_pkg::RST_HIGH_HIGH;
        upper_level      = frc_pkg::RST_HIGH;
        heat_stop_level  = frc_pkg::RST_LOW;
        heat_start_level = frc_pkg::RST_LOW_LOW;
        door_hold        = frc_pkg::RST_DOOR_HOLD;
        heat_timeout     = frc_pkg::RST_HEAT_TMO;
        {trip, startup, by_switch, heat, ember, request, tracking} = '0;
        press_ms = '0;
        heat_ms  = '0;
        errors   = 0;
    endfunction

    function void set_reg(logic [frc_pkg::IDX_W-1:0] idx, logic [31:0] value);
        case (idx)
            frc_pkg::REG_HIGH_HIGH: trip_level       = value[frc_pkg::LIM_W-1:0];
            frc_pkg::REG_HIGH:      upper_level      = value[frc_pkg::LIM_W-1:0];
            frc_pkg::REG_LOW:       heat_stop_level  = value[frc_pkg::LIM_W-1:0];
            frc_pkg::REG_LOW_LOW:   heat_start_level = value[frc_pkg::LIM_W-1:0];
            frc_pkg::REG_DOOR_HOLD: door_hold        = value[frc_pkg::HOLD_W-1:0];
            frc_pkg::REG_HEAT_TMO:  heat_timeout     = value[frc_pkg::HOLD_W-1:0];
            default: ;
        endcase
    endfunction

    // Millisecond counters stick at all ones.
    function logic [frc_pkg::HOLD_W-1:0] bump_ms(logic [frc_pkg::HOLD_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function void apply_door(logic pressed);
        if (startup) return;
        if (!pressed) begin
            tracking = 1'b0;
        end else if (!tracking) begin
            tracking = 1'b1;
            press_ms = '0;
        end else if (press_ms >= door_hold) begin
            request  = 1'b1;
            tracking = 1'b0;
        end
    endfunction

    // Priority chain run by every valid temperature reading.
    function void apply_temperature(logic [frc_pkg::LIM_W-1:0] t);
        if (t >= trip_level) begin
            trip      = 1'b1;
            startup   = 1'b0;
            by_switch = 1'b0;
            ember     = 1'b0;
            request   = 1'b0;
        end else if (trip && t <= upper_level) begin
            trip = 1'b0;
        end else if (request && !startup) begin
            heat      = 1'b1;
            startup   = 1'b1;
            by_switch = 1'b1;
            ember     = 1'b0;
            request   = 1'b0;
        end else if (startup && t >= upper_level) begin
            heat      = 1'b0;
            startup   = 1'b0;
            by_switch = 1'b0;
            request   = 1'b0;
        end else if (t < heat_start_level && !heat && !startup && !ember) begin
            heat    = 1'b1;
            heat_ms = '0;
        end else if (heat && !by_switch && heat_ms >= heat_timeout && t < heat_start_level) begin
            heat  = 1'b0;
            ember = 1'b1;
        end else if (heat && !startup && t >= heat_stop_level && t < upper_level) begin
            heat  = 1'b0;
            ember = 1'b0;
        end
    endfunction

    function void note_item(logic [1:0] op, logic door, logic [12:0] temp);
        t_relay_status want;
        want.report_valid = 1'b0;
        case (op)
            frc_pkg::OP_TICK: begin
                if (tracking) press_ms = bump_ms(press_ms);
                heat_ms = bump_ms(heat_ms);
            end
            frc_pkg::OP_DOOR: apply_door(door);
            frc_pkg::OP_TEMP: begin
                // A set sign bit marks a failed reading, which changes nothing.
                if (!temp[12]) begin
                    want.report_valid = 1'b1;
                    apply_temperature(temp[frc_pkg::LIM_W-1:0]);
                end
            end
            default: ;
        endcase
        want.trip_relay    = trip;
        want.heat_relay    = heat;
        want.startup_on    = startup;
        want.ember_on      = ember;
        want.start_pending = request;
        expected_status.push_back(want);
    endfunction

    function void check_field(string name, logic want, logic got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_status(logic [7:0] data, logic user);
        t_relay_status want;
        if (expected_status.size() == 0) begin
            $error("status transaction %h/%b arrived with none expected", data, user);
            errors++;
            return;
        end
        want = expected_status.pop_front();
        check_field("trip_relay", want.trip_relay, data[0]);
        check_field("heat_relay", want.heat_relay, data[1]);
        check_field("startup_on", want.startup_on, data[2]);
        check_field("ember_on", want.ember_on, data[3]);
        check_field("start_pending", want.start_pending, data[4]);
        if (data[7:5] !== 3'd0) begin
            $error("tdata fill: expected 0, got %0d", data[7:5]);
            errors++;
        end
        check_field("report_valid", want.report_valid, user);
    endfunction
endclass

module furnace_relay_controller_core_tb;
    import frc_pkg::*;

    // The core answers every transaction it takes, in order, so in a legal run
    // the longest stretch without a handshake is the long receiver hold-off
    // below.
    localparam int STALL_LIMIT = 5000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 230;
    localparam int HOLD_OFF    = 300;
    localparam int TDATA_W     = 16;

    // The item kind left unused by the core; it must pass through untouched.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [TDATA_W-1:0] i_s_axis_tdata  = '0;
    logic [1:0]         i_s_axis_tuser  = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [7:0]         o_m_axis_tdata;
    logic               o_m_axis_tuser;
    logic               psel            = 1'b0;
    logic               penable         = 1'b0;
    logic               pwrite          = 1'b0;
    logic [ADDR_W-1:0]  paddr           = '0;
    logic [DATA_W-1:0]  pwdata          = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    int items_sent   = 0;

    relay_scoreboard board;

    furnace_relay_controller_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #2 i_clk = ~i_clk;

    // Output side. Normally ready is random per cycle; when a hold-off is
    // requested this process keeps ready low for that many cycles by itself,
    // so the sender keeps pushing until the core backs up its input.
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_hold_left    <= rx_hold_left - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Every status transaction taken at an edge is checked against the oldest
    // prediction. Signals are read right at the edge, before any update lands.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            board.check_status(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    // Watchdog: ends the run if no transaction moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("furnace_relay_controller_core_tb: done, errors");
        $finish;
    end

    // Offers one item and returns at the edge where it was taken. The valid
    // stays high afterwards so that back-to-back items follow without a gap; it
    // is dropped only when the next call decides to idle or drain() stops sending.
    task automatic send_item(input logic [1:0] op, input logic door, input logic [12:0] temp);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {2'b00, temp, door};
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_item(op, door, temp);
        items_sent++;
    endtask

    // Stops sending and waits until every predicted status has come back.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.expected_status.size() != 0);
    endtask

    // APB write: a setup phase, then an access phase that completes on pready.
    // The bus is left selected so that writes can follow back to back.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_reg(idx, value);
    endtask

    // Loads all six registers. The core must be empty first, and the extra
    // cycles cover its input and result registers.
    task automatic load_limits(input int hh, input int hi, input int lo, input int ll,
                               input logic [HOLD_W-1:0] hold, input logic [HOLD_W-1:0] tmo);
        drain();
        repeat (3) @(posedge i_clk);
        write_reg(REG_HIGH_HIGH, hh);
        write_reg(REG_HIGH, hi);
        write_reg(REG_LOW, lo);
        write_reg(REG_LOW_LOW, ll);
        write_reg(REG_DOOR_HOLD, 32'(hold));
        write_reg(REG_HEAT_TMO, 32'(tmo));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Temperatures cluster around the current thresholds, where the priority
    // chain changes its mind; some are failed readings or fully random.
    function automatic logic [12:0] pick_temp();
        int lvl;
        case ($urandom_range(9))
            0: return 13'($urandom);
            1: return {1'b1, 12'($urandom)};
            2: return {1'b0, 12'($urandom)};
            default: begin
                case ($urandom_range(3))
                    0:       lvl = int'(board.trip_level);
                    1:       lvl = int'(board.upper_level);
                    2:       lvl = int'(board.heat_stop_level);
                    default: lvl = int'(board.heat_start_level);
                endcase
                lvl = lvl + int'($urandom_range(6)) - 3;
                if (lvl < 0) lvl = 0;
                else if (lvl > 4095) lvl = 4095;
                return 13'(lvl);
            end
        endcase
    endfunction

    initial begin
        int phase, pick, n, phase_end, pause_at;
        int ll, lo, hi, hh;
        bit paused;
        logic [1:0] op;

        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, first under the reset values of the registers: a cold
        // reading turns forced heat on, failed readings and the unused kind
        // change nothing, and the hottest reading trips the relay.
        send_item(OP_TEMP, 1'b0, 13'd0);
        send_item(OP_TEMP, 1'b1, 13'h1FFF);
        send_item(OP_TEMP, 1'b0, 13'h1000);
        send_item(OP_UNUSED, 1'b1, 13'd4095);
        send_item(OP_TEMP, 1'b1, 13'd4095);
        send_item(OP_DOOR, 1'b0, 13'h0AAA);
        send_item(OP_TICK, 1'b1, 13'h1555);

        // Short hold and timeout so that both timers matter within a few ticks.
        load_limits(1400, 1200, 400, 200, 26'd2, 26'd3);
        send_item(OP_TEMP, 1'b0, 13'd1200);      // trip clears at the upper level
        send_item(OP_DOOR, 1'b1, 13'd0);         // press starts being timed
        repeat (3) send_item(OP_TICK, 1'b0, 13'd0);
        send_item(OP_DOOR, 1'b1, 13'd0);         // held long enough: start request
        send_item(OP_TEMP, 1'b0, 13'd1000);      // request starts the startup heat
        send_item(OP_DOOR, 1'b1, 13'd0);         // door ignored during startup
        send_item(OP_TEMP, 1'b0, 13'd1300);      // upper level ends startup
        send_item(OP_TEMP, 1'b0, 13'd100);       // cold: ordinary forced heat
        repeat (4) send_item(OP_TICK, 1'b0, 13'd0);
        send_item(OP_TEMP, 1'b0, 13'd100);       // heat timed out: ember hold
        send_item(OP_TEMP, 1'b0, 13'd50);
        send_item(OP_TEMP, 1'b0, 13'd1400);      // trip cancels the ember hold
        send_item(OP_TEMP, 1'b0, 13'd1200);
        send_item(OP_TEMP, 1'b0, 13'd100);
        send_item(OP_TEMP, 1'b0, 13'd500);       // warm enough: forced heat stops

        // Random part. Each phase loads its own thresholds, including both
        // extremes, and runs one of the idling patterns.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: load_limits(0, 0, 0, 0, '0, '0);
                1: load_limits(4095, 4095, 4095, 4095, '1, '1);
                5: load_limits($urandom_range(4095), $urandom_range(4095),
                               $urandom_range(4095), $urandom_range(4095),
                               HOLD_W'($urandom_range(6)), HOLD_W'($urandom_range(30)));
                default: begin
                    ll = $urandom_range(1000);
                    lo = ll + $urandom_range(1000);
                    hi = lo + $urandom_range(1000);
                    hh = hi + $urandom_range(1000);
                    load_limits(hh, hi, lo, ll, HOLD_W'($urandom_range(6)),
                                HOLD_W'($urandom_range(30)));
                end
            endcase

            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
                default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
            endcase

            // Long receiver hold-off while items keep coming, so the core fills.
            if (phase == 2) rx_hold_left = HOLD_OFF;

            phase_end = items_sent + PHASE_ITEMS;
            pause_at  = items_sent + PHASE_ITEMS / 2;
            paused    = 1'b0;
            while (items_sent < phase_end) begin
                // Halfway through, the sender waits for every result to return.
                if (!paused && items_sent >= pause_at) begin
                    drain();
                    paused = 1'b1;
                end
                pick = $urandom_range(99);
                if (pick < 30) begin
                    // A door press held across some ticks, then a reading.
                    send_item(OP_DOOR, 1'b1, 13'($urandom));
                    n = (board.door_hold > 10) ? $urandom_range(10)
                                               : $urandom_range(board.door_hold + 2);
                    repeat (n) send_item(OP_TICK, 1'($urandom), 13'($urandom));
                    send_item(OP_DOOR, $urandom_range(9) != 0, 13'($urandom));
                    send_item(OP_TEMP, 1'($urandom), pick_temp());
                end else if (pick < 45) begin
                    // A run of ticks that can be long enough to reach a short heat timeout.
                    n = (board.heat_timeout > 36) ? $urandom_range(1, 40)
                                                  : $urandom_range(1, board.heat_timeout + 4);
                    repeat (n) send_item(OP_TICK, 1'($urandom), 13'($urandom));
                    send_item(OP_TEMP, 1'($urandom), pick_temp());
                end else if (pick < 55) begin
                    repeat ($urandom_range(2, 5)) send_item(OP_TEMP, 1'($urandom), pick_temp());
                end else begin
                    // Single items of any kind, the unused one now and then.
                    case ($urandom_range(19))
                        0:       op = OP_UNUSED;
                        1, 2, 3, 4, 5, 6: op = OP_TICK;
                        7, 8, 9, 10, 11:  op = OP_DOOR;
                        default: op = OP_TEMP;
                    endcase
                    send_item(op, 1'($urandom), (op == OP_TEMP) ? pick_temp() : 13'($urandom));
                end
            end
        end

        // All items sent: wait for the last results, then keep watching to catch
        // anything the core would emit unasked.
        drain();
        repeat (10) @(posedge i_clk);
        if (board.errors == 0 && board.expected_status.size() == 0)
            $display("furnace_relay_controller_core_tb: done, clean");
        else
            $display("furnace_relay_controller_core_tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/frc_pkg.sv
hw/rtl/frc_cfg_regs.sv
hw/rtl/frc_step.sv
hw/rtl/furnace_relay_controller_core.sv
hw/rtl/frc_checker.sv
sim/furnace_relay_controller_core_tb.sv
